// ===== hw/rtl/ncps_pkg.sv =====
// ----------------------------------------------------------------------------
// ncps_pkg
// Shared types, widths and codes for the nearest centerline point snap block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncps_pkg;

  // Coordinate and distance widths
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned DIFF_W    = COORD_W + 1;       // difference of two coords
  localparam int unsigned SQ_W      = 2 * COORD_W + 1;   // one squared difference
  localparam int unsigned DIST_W    = SQ_W + 1;          // sum of three squares
  localparam int unsigned IDX_OUT_W = 10;                // point_index port width

  // Configuration register file
  localparam int unsigned MAXD_W     = 16;
  localparam int unsigned LIMIT_W    = 2 * MAXD_W;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_MAX_DISTANCE = '0;
  localparam logic [MAXD_W-1:0]    MAX_DISTANCE_RST = 16'd7680;

  // Store depth default
  localparam int unsigned MAX_POINTS_DEF = 1024;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nearest_centerline_point_snap_core.sv =====
// ----------------------------------------------------------------------------
// nearest_centerline_point_snap_core
// Stores up to MAX_POINTS centerline points and snaps a tool position to the
// nearest stored point when it lies closer than max_distance.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries op and x, y, z. A clear or
// an append completes when taken; an append to a full store is dropped. A query
// produces one output transaction (out_valid_o / out_stall_i); clear and
// append produce none.
// A query streams the stored points through one registered read port of the
// point memory into a shared three stage squared distance unit, one point per
// cycle, followed by a running minimum whose result is loaded into the result
// register; an empty store skips the scan. That read port and distance unit
// set the rate. in_stall_o is high for the whole query.
// The result sits in an output register: while the receiver stalls, clears
// and appends are still taken, and a following query holds its result
// until the register frees up.
// Reset (rst_ni low, asynchronous) empties the store, sets max_distance to
// 7680 and drops any pending result. Store contents are not cleared; only
// entries below the fill count are ever read.
// max_distance is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_centerline_point_snap_core #(
  parameter int unsigned MAX_POINTS = ncps_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // APB configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [ncps_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [ncps_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [ncps_pkg::APB_DATA_W-1:0]            prdata,
  output logic                                       pready,
  // Input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [1:0]                            op_i,
  input  wire logic signed [ncps_pkg::COORD_W-1:0]   in_x_i,
  input  wire logic signed [ncps_pkg::COORD_W-1:0]   in_y_i,
  input  wire logic signed [ncps_pkg::COORD_W-1:0]   in_z_i,
  // Output channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [ncps_pkg::COORD_W-1:0]        out_x_o,
  output logic signed [ncps_pkg::COORD_W-1:0]        out_y_o,
  output logic signed [ncps_pkg::COORD_W-1:0]        out_z_o,
  output logic                                       found_o,
  output logic [ncps_pkg::IDX_OUT_W-1:0]             point_index_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned XW = (AW > ncps_pkg::IDX_OUT_W) ? AW : ncps_pkg::IDX_OUT_W;
  localparam int unsigned DTW = ncps_pkg::DIST_W;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [ncps_pkg::MAXD_W-1:0]    max_dist_q;
  logic [ncps_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;

  assign reg_idx = paddr[ncps_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= ncps_pkg::MAX_DISTANCE_RST;
    end else if (cfg_wr && (reg_idx == ncps_pkg::REG_MAX_DISTANCE)) begin
      max_dist_q <= pwdata[ncps_pkg::MAXD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == ncps_pkg::REG_MAX_DISTANCE) begin
      prdata = ncps_pkg::APB_DATA_W'(max_dist_q);
    end
  end

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  ncps_pkg::state_e state_q, state_d;
  ncps_pkg::op_e    op;
  ncps_pkg::point_t in_pt, tool_q, rd_pt, dist_pt, best_pt_q;

  logic [CW-1:0]  count_q;
  logic [AW-1:0]  addr_q, rd_idx_q, dist_idx, best_idx_q;
  logic           rd_vld_q, dist_vld, dist_busy;
  logic [DTW-1:0] dist_val, best_d_q;
  logic           have_q;
  logic [ncps_pkg::LIMIT_W-1:0] limit_q;

  logic do_clear, do_append, do_query, empty;
  logic scan_rd, scan_last, scan_start, out_load, found;
  logic out_valid_q;
  logic [XW-1:0] idx_wide;

  assign op    = ncps_pkg::op_e'(op_i);
  assign in_pt = '{x: in_x_i, y: in_y_i, z: in_z_i};
  assign empty = (count_q == '0);

  assign scan_last  = ((CW'(addr_q) + CW'(1)) == count_q);

  // --------------------------------------------------------------------------
  // Sequencer: next state and controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    do_clear   = 1'b0;
    do_append  = 1'b0;
    do_query   = 1'b0;
    scan_rd    = 1'b0;
    scan_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ncps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (op)
            ncps_pkg::OP_CLEAR:  do_clear  = 1'b1;
            ncps_pkg::OP_APPEND: do_append = (count_q < CW'(MAX_POINTS));
            ncps_pkg::OP_QUERY: begin
              do_query = 1'b1;
              if (empty) begin
                state_d = ncps_pkg::ST_FINISH;
              end else begin
                scan_start = 1'b1;
                state_d    = ncps_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ncps_pkg::ST_SCAN: begin
        scan_rd = 1'b1;
        if (scan_last) begin
          state_d = ncps_pkg::ST_DRAIN;
        end
      end
      ncps_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !dist_busy) begin
          state_d = ncps_pkg::ST_FINISH;
        end
      end
      ncps_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ncps_pkg::ST_IDLE;
        end
      end
      default: state_d = ncps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Fill count and scan address
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= scan_rd;
      if (do_clear) begin
        count_q <= '0;
      end else if (do_append) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (scan_start) begin
      addr_q <= '0;
    end else if (scan_rd) begin
      addr_q <= addr_q + AW'(1);
    end
  end

  // Tool position and squared threshold, held for the query
  always_ff @(posedge clk_i) begin
    if (do_query) begin
      tool_q  <= in_pt;
      limit_q <= max_dist_q * max_dist_q;
    end
  end

  // --------------------------------------------------------------------------
  // Point store
  // --------------------------------------------------------------------------
  ncps_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (do_append),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_pt),
    .re_i    (scan_rd),
    .raddr_i (addr_q),
    .rdata_o (rd_pt)
  );

  // --------------------------------------------------------------------------
  // Shared squared distance unit
  // --------------------------------------------------------------------------
  ncps_dist_unit #(
    .AW (AW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .idx_i  (rd_idx_q),
    .pt_i   (rd_pt),
    .tool_i (tool_q),
    .vld_o  (dist_vld),
    .idx_o  (dist_idx),
    .pt_o   (dist_pt),
    .dist_o (dist_val),
    .busy_o (dist_busy)
  );

  // --------------------------------------------------------------------------
  // Running minimum, first index wins on ties
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (do_query) begin
      have_q <= 1'b0;
    end else if (dist_vld) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_vld && (!have_q || (dist_val < best_d_q))) begin
      best_d_q   <= dist_val;
      best_idx_q <= dist_idx;
      best_pt_q  <= dist_pt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign found    = have_q & (best_d_q < DTW'(limit_q));
  assign idx_wide = XW'(best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_o <= found;
      if (found) begin
        out_x_o       <= best_pt_q.x;
        out_y_o       <= best_pt_q.y;
        out_z_o       <= best_pt_q.z;
        point_index_o <= idx_wide[ncps_pkg::IDX_OUT_W-1:0];
      end else begin
        out_x_o       <= tool_q.x;
        out_y_o       <= tool_q.y;
        out_z_o       <= tool_q.z;
        point_index_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ncps_point_mem.sv =====
// ----------------------------------------------------------------------------
// ncps_point_mem
// Single write port, single registered read port store of centerline points.
// ----------------------------------------------------------------------------
`default_nettype none

module ncps_point_mem #(
  parameter int unsigned DEPTH = ncps_pkg::MAX_POINTS_DEF,
  parameter int unsigned AW    = 10
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire ncps_pkg::point_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output ncps_pkg::point_t     rdata_o
);

  ncps_pkg::point_t mem_q [DEPTH];
  ncps_pkg::point_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ncps_dist_unit.sv =====
// ----------------------------------------------------------------------------
// ncps_dist_unit
// Three stage squared distance unit shared by every point of a scan:
// difference, square, sum. Index and point ride along with the data.
// ----------------------------------------------------------------------------
`default_nettype none

module ncps_dist_unit #(
  parameter int unsigned AW = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire logic [AW-1:0]                 idx_i,
  input  wire ncps_pkg::point_t              pt_i,
  input  wire ncps_pkg::point_t              tool_i,
  output logic                               vld_o,
  output logic [AW-1:0]                      idx_o,
  output ncps_pkg::point_t                   pt_o,
  output logic [ncps_pkg::DIST_W-1:0]        dist_o,
  output logic                               busy_o
);

  localparam int unsigned DW = ncps_pkg::DIFF_W;
  localparam int unsigned PW = 2 * ncps_pkg::DIFF_W;

  // Stage valids
  logic s1_vld_q, s2_vld_q, s3_vld_q;

  // Stage payloads
  logic [AW-1:0]     s1_idx_q, s2_idx_q, s3_idx_q;
  ncps_pkg::point_t  s1_pt_q, s2_pt_q, s3_pt_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic signed [DW-1:0] s1_dx_d, s1_dy_d, s1_dz_d;
  logic [ncps_pkg::SQ_W-1:0] s2_sqx_q, s2_sqy_q, s2_sqz_q;
  logic signed [PW-1:0] prod_x, prod_y, prod_z;
  logic [ncps_pkg::DIST_W-1:0] s3_dist_q, s3_dist_d;

  // Stage 1: sign extended differences
  always_comb begin
    s1_dx_d = DW'(pt_i.x) - DW'(tool_i.x);
    s1_dy_d = DW'(pt_i.y) - DW'(tool_i.y);
    s1_dz_d = DW'(pt_i.z) - DW'(tool_i.z);
  end

  // Stage 2: squares, always non-negative and below 2^48
  always_comb begin
    prod_x = s1_dx_q * s1_dx_q;
    prod_y = s1_dy_q * s1_dy_q;
    prod_z = s1_dz_q * s1_dz_q;
  end

  // Stage 3: sum of squares
  always_comb begin
    s3_dist_d = ncps_pkg::DIST_W'(s2_sqx_q) + ncps_pkg::DIST_W'(s2_sqy_q)
              + ncps_pkg::DIST_W'(s2_sqz_q);
  end

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= idx_i;
    s1_pt_q   <= pt_i;
    s1_dx_q   <= s1_dx_d;
    s1_dy_q   <= s1_dy_d;
    s1_dz_q   <= s1_dz_d;
    s2_idx_q  <= s1_idx_q;
    s2_pt_q   <= s1_pt_q;
    s2_sqx_q  <= prod_x[ncps_pkg::SQ_W-1:0];
    s2_sqy_q  <= prod_y[ncps_pkg::SQ_W-1:0];
    s2_sqz_q  <= prod_z[ncps_pkg::SQ_W-1:0];
    s3_idx_q  <= s2_idx_q;
    s3_pt_q   <= s2_pt_q;
    s3_dist_q <= s3_dist_d;
  end

  assign vld_o  = s3_vld_q;
  assign idx_o  = s3_idx_q;
  assign pt_o   = s3_pt_q;
  assign dist_o = s3_dist_q;
  assign busy_o = s1_vld_q | s2_vld_q | s3_vld_q;

endmodule

`default_nettype wire
